>>> design/tfrh_pkg.sv
// Shared types and constants for the two-field radix histogram.
package tfrh_pkg;

	localparam int INDEX_BITS_DEF = 10;

	localparam int HASH_W  = 32;
	localparam int BIN_W   = 10;
	localparam int COUNT_W = 32;

	localparam int FBITS_W  = 4;
	localparam int FSHIFT_W = 5;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [1:0] REG_HIGH_BITS  = 2'd0;
	localparam logic [1:0] REG_HIGH_SHIFT = 2'd1;
	localparam logic [1:0] REG_LOW_BITS   = 2'd2;
	localparam logic [1:0] REG_LOW_SHIFT  = 2'd3;

	typedef struct packed {
		logic [FBITS_W-1:0]  high_field_bits;
		logic [FSHIFT_W-1:0] high_field_shift;
		logic [FBITS_W-1:0]  low_field_bits;
		logic [FSHIFT_W-1:0] low_field_shift;
	} cfg_t;

	typedef struct packed {
		logic [BIN_W-1:0]   bin_index;
		logic [COUNT_W-1:0] bin_count;
	} result_t;

endpackage

>>> design/tfrh_if.sv
// Valid/ready channel interfaces for hash items and histogram results.
interface tfrh_in_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [tfrh_pkg::HASH_W-1:0] hash_word;
	logic [tfrh_pkg::BIN_W-1:0]  read_bin;

	modport source (output valid, output opcode, output hash_word, output read_bin,
		input ready);
	modport sink (input valid, input opcode, input hash_word, input read_bin,
		output ready);
endinterface

interface tfrh_out_if;
	logic                         valid;
	logic                         ready;
	logic [tfrh_pkg::BIN_W-1:0]   bin_index;
	logic [tfrh_pkg::COUNT_W-1:0] bin_count;

	modport source (output valid, output bin_index, output bin_count, input ready);
	modport sink (input valid, input bin_index, input bin_count, output ready);
endinterface

>>> design/tfrh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tfrh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/tfrh_out_fifo.sv
// Small result FIFO that drives the result channel.
module tfrh_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  tfrh_pkg::result_t                 push_data,
	output logic [tfrh_pkg::OUT_LVL_W-1:0]    level,
	tfrh_out_if.source                        result
);

	localparam logic [tfrh_pkg::OUT_PTR_W-1:0] LAST_PTR =
		tfrh_pkg::OUT_PTR_W'(tfrh_pkg::OUT_DEPTH - 1);

	tfrh_pkg::result_t                  buf_q [tfrh_pkg::OUT_DEPTH];
	logic [tfrh_pkg::OUT_PTR_W-1:0]     wr_ptr_q;
	logic [tfrh_pkg::OUT_PTR_W-1:0]     rd_ptr_q;
	logic [tfrh_pkg::OUT_LVL_W-1:0]     level_q;
	logic                               pop;

	assign pop              = result.valid && result.ready;
	assign level            = level_q;
	assign result.valid     = (level_q != '0);
	assign result.bin_index = buf_q[rd_ptr_q].bin_index;
	assign result.bin_count = buf_q[rd_ptr_q].bin_count;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

>>> design/two_field_radix_histogram.sv
// Top level: radix-partition histogram with two configurable hash bit fields.
// Result path: an accepted item is registered (v_s1), then pushed into the result FIFO.
// Throughput: one item per cycle while the result FIFO has room; each count is a
// read-modify-write of the count RAM (registered read), with the previous cycle's write
// forwarded on a same-bin hit. Reset: config registers clear to 0, then a clearing pass
// writes zero to every bin, during which no item is accepted.
module two_field_radix_histogram #(
	parameter int INDEX_BITS = tfrh_pkg::INDEX_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tfrh_in_if.sink                          item,
	tfrh_out_if.source                       result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tfrh_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [tfrh_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tfrh_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	localparam int DEPTH = 1 << INDEX_BITS;
	localparam int JW    = 31;

	tfrh_pkg::cfg_t                    cfg_q;
	logic [1:0]                        reg_sel;

	logic [INDEX_BITS-1:0]             clr_idx_q;
	logic                              clr_done_q;

	logic [tfrh_pkg::HASH_W-1:0]       hsh_hi;
	logic [tfrh_pkg::HASH_W-1:0]       hsh_lo;
	logic [tfrh_pkg::HASH_W-1:0]       mask_hi;
	logic [tfrh_pkg::HASH_W-1:0]       mask_lo;
	logic [14:0]                       fld_hi;
	logic [14:0]                       fld_lo;
	logic [JW-1:0]                     joined;
	logic [INDEX_BITS-1:0]             idx_in;
	logic                              acc;

	logic                              v_s1;
	logic                              op_s1;
	logic [INDEX_BITS-1:0]             idx_s1;

	logic [tfrh_pkg::COUNT_W-1:0]      ram_rdata;
	logic [tfrh_pkg::COUNT_W-1:0]      cur_cnt;
	logic [tfrh_pkg::COUNT_W-1:0]      new_cnt;
	logic                              upd_we;
	logic                              ram_we;
	logic [INDEX_BITS-1:0]             ram_waddr;
	logic [tfrh_pkg::COUNT_W-1:0]      ram_wdata;

	logic                              wr_v_q;
	logic [INDEX_BITS-1:0]             wr_idx_q;
	logic [tfrh_pkg::COUNT_W-1:0]      wr_data_q;

	tfrh_pkg::result_t                 push_data;
	logic [tfrh_pkg::OUT_LVL_W-1:0]    out_level;

	// APB configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];

	always_comb begin
		unique case (reg_sel)
			tfrh_pkg::REG_HIGH_BITS:  prdata = tfrh_pkg::APB_DATA_W'(cfg_q.high_field_bits);
			tfrh_pkg::REG_HIGH_SHIFT: prdata = tfrh_pkg::APB_DATA_W'(cfg_q.high_field_shift);
			tfrh_pkg::REG_LOW_BITS:   prdata = tfrh_pkg::APB_DATA_W'(cfg_q.low_field_bits);
			tfrh_pkg::REG_LOW_SHIFT:  prdata = tfrh_pkg::APB_DATA_W'(cfg_q.low_field_shift);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				tfrh_pkg::REG_HIGH_BITS:  cfg_q.high_field_bits  <= pwdata[3:0];
				tfrh_pkg::REG_HIGH_SHIFT: cfg_q.high_field_shift <= pwdata[4:0];
				tfrh_pkg::REG_LOW_BITS:   cfg_q.low_field_bits   <= pwdata[3:0];
				tfrh_pkg::REG_LOW_SHIFT:  cfg_q.low_field_shift  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// Bin index from the two hash fields, or the read bin for a read
	always_comb begin
		hsh_hi  = item.hash_word >> cfg_q.high_field_shift;
		hsh_lo  = item.hash_word >> cfg_q.low_field_shift;
		mask_hi = (32'd1 << cfg_q.high_field_bits) - 32'd1;
		mask_lo = (32'd1 << cfg_q.low_field_bits) - 32'd1;
		fld_hi  = hsh_hi[14:0] & mask_hi[14:0];
		fld_lo  = hsh_lo[14:0] & mask_lo[14:0];
		joined  = (JW'(fld_hi) << cfg_q.low_field_bits) | JW'(fld_lo);
		if (item.opcode == tfrh_pkg::OP_READ) begin
			idx_in = INDEX_BITS'(item.read_bin);
		end else begin
			idx_in = joined[INDEX_BITS-1:0];
		end
	end

	// Room for the item in flight plus the new one in the result FIFO
	assign item.ready = clr_done_q &&
		((tfrh_pkg::OUT_LVL_W'(v_s1) + out_level) < tfrh_pkg::OUT_LVL_W'(tfrh_pkg::OUT_DEPTH));
	assign acc = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1  <= item.opcode;
			idx_s1 <= idx_in;
		end
	end

	tfrh_ram #(
		.WIDTH(tfrh_pkg::COUNT_W),
		.DEPTH(DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	// Read-modify-write with forwarding of last cycle's write
	always_comb begin
		cur_cnt   = (wr_v_q && (wr_idx_q == idx_s1)) ? wr_data_q : ram_rdata;
		new_cnt   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
		upd_we    = v_s1 && (op_s1 == tfrh_pkg::OP_COUNT);
		ram_we    = upd_we || !clr_done_q;
		ram_waddr = clr_done_q ? idx_s1 : clr_idx_q;
		ram_wdata = clr_done_q ? new_cnt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q <= 1'b0;
		end else begin
			wr_v_q <= upd_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_idx_q  <= idx_s1;
		wr_data_q <= new_cnt;
	end

	always_comb begin
		push_data.bin_index = tfrh_pkg::BIN_W'(idx_s1);
		push_data.bin_count = (op_s1 == tfrh_pkg::OP_READ) ? cur_cnt : new_cnt;
	end

	tfrh_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (push_data),
		.level     (out_level),
		.result    (result)
	);

endmodule

>>> tb/two_field_radix_histogram_tb.sv
// Testbench for two_field_radix_histogram: directed and random traffic, bin-count scoreboard.
`timescale 1ns / 100ps

module two_field_radix_histogram_tb;

	localparam int BIN_DEPTH = 1 << tfrh_pkg::INDEX_BITS_DEF;

	class histogram_scoreboard;
		tfrh_pkg::cfg_t                cfg;
		logic [tfrh_pkg::COUNT_W-1:0]  counts[BIN_DEPTH];
		tfrh_pkg::result_t             expected_bins[$];
		logic [tfrh_pkg::BIN_W-1:0]    last_bin;
		int                            errors;

		function new();
			cfg = '0;
			last_bin = '0;
			errors = 0;
			foreach (counts[i]) counts[i] = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				tfrh_pkg::REG_HIGH_BITS:
					cfg.high_field_bits  = value[tfrh_pkg::FBITS_W-1:0];
				tfrh_pkg::REG_HIGH_SHIFT:
					cfg.high_field_shift = value[tfrh_pkg::FSHIFT_W-1:0];
				tfrh_pkg::REG_LOW_BITS:
					cfg.low_field_bits   = value[tfrh_pkg::FBITS_W-1:0];
				tfrh_pkg::REG_LOW_SHIFT:
					cfg.low_field_shift  = value[tfrh_pkg::FSHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [tfrh_pkg::BIN_W-1:0] bin_of(logic [tfrh_pkg::HASH_W-1:0] hash);
			logic [63:0] hi;
			logic [63:0] lo;
			logic [63:0] joined;
			hi = ({32'd0, hash} >> cfg.high_field_shift) &
				((64'd1 << cfg.high_field_bits) - 64'd1);
			lo = ({32'd0, hash} >> cfg.low_field_shift) &
				((64'd1 << cfg.low_field_bits) - 64'd1);
			joined = (hi << cfg.low_field_bits) | lo;
			return joined[tfrh_pkg::BIN_W-1:0];
		endfunction

		function void accept_item(logic op, logic [tfrh_pkg::HASH_W-1:0] hash,
			logic [tfrh_pkg::BIN_W-1:0] rb);
			tfrh_pkg::result_t r;
			if (op == tfrh_pkg::OP_COUNT) begin
				r.bin_index = bin_of(hash);
				if (counts[r.bin_index] != '1)
					counts[r.bin_index] = counts[r.bin_index] + 1;
				last_bin = r.bin_index;
			end else begin
				r.bin_index = rb;
			end
			r.bin_count = counts[r.bin_index];
			expected_bins.push_back(r);
		endfunction

		function void check_result(logic [tfrh_pkg::BIN_W-1:0] idx,
			logic [tfrh_pkg::COUNT_W-1:0] cnt);
			tfrh_pkg::result_t want;
			if (expected_bins.size() == 0) begin
				$display("%0t unexpected result: bin_index %0d bin_count %0d", $time, idx, cnt);
				errors++;
				return;
			end
			want = expected_bins.pop_front();
			if (idx !== want.bin_index) begin
				$display("%0t bin_index: expected %0d, actual %0d", $time, want.bin_index, idx);
				errors++;
			end
			if (cnt !== want.bin_count) begin
				$display("%0t bin_count (bin %0d): expected %0d, actual %0d",
					$time, want.bin_index, want.bin_count, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return expected_bins.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [tfrh_pkg::APB_ADDR_W-1:0] paddr;
	logic [tfrh_pkg::APB_DATA_W-1:0] pwdata;
	logic [tfrh_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	bit gaps_on;
	bit stalls_on;

	histogram_scoreboard sb = new();

	tfrh_in_if  in_ch ();
	tfrh_out_if out_ch ();

	two_field_radix_histogram dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (in_ch),
		.result  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[two_field_radix_histogram] ERROR");
		$finish;
	end

	// result sink with random back-pressure
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			stall = stalls_on ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_result(out_ch.bin_index, out_ch.bin_count);
			@(negedge clk);
		end
	end

	task automatic send_item(logic op, logic [tfrh_pkg::HASH_W-1:0] hash,
		logic [tfrh_pkg::BIN_W-1:0] rb);
		int gap;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.hash_word <= hash;
		in_ch.read_bin  <= rb;
		do @(posedge clk); while (!in_ch.ready);
		sb.accept_item(op, hash, rb);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(reg_idx, value);
		@(negedge clk);
	endtask

	task automatic apply_cfg(int hb, int hs, int lb, int ls);
		drain();
		apb_write(tfrh_pkg::REG_HIGH_BITS, hb);
		apb_write(tfrh_pkg::REG_HIGH_SHIFT, hs);
		apb_write(tfrh_pkg::REG_LOW_BITS, lb);
		apb_write(tfrh_pkg::REG_LOW_SHIFT, ls);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [tfrh_pkg::HASH_W-1:0] hash;
		logic [tfrh_pkg::BIN_W-1:0]  rb;
		logic                        op;

		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = tfrh_pkg::OP_COUNT;
		in_ch.hash_word = '0;
		in_ch.read_bin  = '0;
		gaps_on         = 1'b1;
		stalls_on       = 1'b1;
		hash            = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: both widths zero, everything lands in bin 0
		send_item(tfrh_pkg::OP_COUNT, 32'h0000_0000, 10'h3FF);
		send_item(tfrh_pkg::OP_COUNT, 32'hFFFF_FFFF, 10'h000);
		send_item(tfrh_pkg::OP_READ, 32'hFFFF_FFFF, 10'h000);
		send_item(tfrh_pkg::OP_READ, 32'h0000_0000, 10'h3FF);

		// widest high field at the top of the hash
		apply_cfg(10, 22, 0, 0);
		send_item(tfrh_pkg::OP_COUNT, 32'hFFC0_0000, 10'h000);
		send_item(tfrh_pkg::OP_COUNT, 32'hFFFF_FFFF, 10'h155);
		send_item(tfrh_pkg::OP_READ, 32'h1234_5678, 10'h3FF);

		// high field runs past bit 31; joined index wraps
		apply_cfg(10, 31, 10, 0);
		send_item(tfrh_pkg::OP_COUNT, 32'h8000_03FF, 10'h2AA);
		send_item(tfrh_pkg::OP_COUNT, 32'h0000_0155, 10'h000);
		send_item(tfrh_pkg::OP_READ, 32'hDEAD_BEEF, 10'h155);
		send_item(tfrh_pkg::OP_READ, 32'h0000_0000, 10'h3FF);

		apply_cfg(5, 27, 5, 0);
		send_item(tfrh_pkg::OP_COUNT, 32'hF800_001F, 10'h000);
		send_item(tfrh_pkg::OP_COUNT, 32'h0800_0001, 10'h3FF);
		send_item(tfrh_pkg::OP_COUNT, 32'h0800_0001, 10'h3FF);
		send_item(tfrh_pkg::OP_READ, 32'h0000_0000, 10'd33);
		send_item(tfrh_pkg::OP_READ, 32'hFFFF_FFFF, 10'h3FF);

		apply_cfg(0, 31, 0, 31);
		send_item(tfrh_pkg::OP_COUNT, 32'hA5A5_5A5A, 10'h155);
		send_item(tfrh_pkg::OP_READ, 32'h0000_0000, 10'h000);

		apply_cfg(0, 0, 10, 31);
		send_item(tfrh_pkg::OP_COUNT, 32'h8000_0000, 10'h000);
		send_item(tfrh_pkg::OP_READ, 32'h0000_0000, 10'h001);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_cfg(3, 29, 2, 0);
				1: apply_cfg(10, 0, 10, 22);
				default: apply_cfg($urandom_range(0, 10), $urandom_range(0, 31),
					$urandom_range(0, 10), $urandom_range(0, 31));
			endcase
			gaps_on   = (p % 3) != 1;
			stalls_on = (p % 3) == 0;
			for (int n = 0; n < 225; n++) begin
				op = ($urandom_range(0, 3) == 0) ? tfrh_pkg::OP_READ : tfrh_pkg::OP_COUNT;
				if (op == tfrh_pkg::OP_COUNT && $urandom_range(0, 9) < 3)
					hash = hash;
				else
					hash = $urandom;
				if ($urandom_range(0, 1) == 1)
					rb = sb.last_bin;
				else
					rb = tfrh_pkg::BIN_W'($urandom);
				send_item(op, hash, rb);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[two_field_radix_histogram] OK");
		else
			$display("[two_field_radix_histogram] ERROR");
		$finish;
	end

endmodule

>>> two_field_radix_histogram.f
design/tfrh_pkg.sv
design/tfrh_if.sv
design/tfrh_ram.sv
design/tfrh_out_fifo.sv
design/two_field_radix_histogram.sv
tb/two_field_radix_histogram_tb.sv
